FILE: sv/sbdt_pkg.sv
// Shared types and constants for the signed binary to decimal text unit.
// No dependencies; imported by every module of the block.
`default_nettype none

package sbdt_pkg;

  localparam int VALUE_BITS_DEF = 128;
  localparam int MAX_DIGITS_DEF = 40;
  localparam int HALF_BITS      = 64;
  localparam int CHAR_BITS      = 6;

  localparam logic [CHAR_BITS-1:0] CHAR_MINUS = 6'd45;
  localparam logic [CHAR_BITS-1:0] CHAR_ZERO  = 6'd48;

  typedef struct packed {
    logic [HALF_BITS-1:0] value_high;
    logic [HALF_BITS-1:0] value_low;
  } sbdt_in_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 last_char;
  } sbdt_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SIGN,
    ST_SKIP,
    ST_EMIT
  } sbdt_state_t;

  // Controller to datapath.
  typedef struct packed {
    logic load;
    logic step;
    logic sign_out;
    logic digit_out;
    logic digit_skip;
  } sbdt_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic bit_last;
    logic dig_last;
    logic top_nz;
    logic negative;
  } sbdt_stat_t;

endpackage

`default_nettype wire

FILE: sv/sbdt_ctrl.sv
// Controller state machine of the decimal text unit.
// Depends on sbdt_pkg; drives sbdt_dp through command and status structs.
`default_nettype none

module sbdt_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  input  sbdt_pkg::sbdt_stat_t stat,
  output sbdt_pkg::sbdt_cmd_t  cmd,
  output logic                busy
);
  import sbdt_pkg::*;

  sbdt_state_t state;
  sbdt_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_CONV;
        end
      end
      ST_CONV: begin
        if (stat.bit_last) begin
          state_next = stat.negative ? ST_SIGN : ST_SKIP;
        end
      end
      ST_SIGN: begin
        state_next = ST_SKIP;
      end
      ST_SKIP: begin
        if (stat.dig_last) begin
          state_next = ST_IDLE;
        end else if (stat.top_nz) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.dig_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd  = '0;
    busy = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy     = 1'b0;
        cmd.load = start;
      end
      ST_CONV: begin
        cmd.step = 1'b1;
      end
      ST_SIGN: begin
        cmd.sign_out = 1'b1;
      end
      ST_SKIP: begin
        // drop leading zeros, but always send the units digit
        if (stat.top_nz || stat.dig_last) begin
          cmd.digit_out = 1'b1;
        end else begin
          cmd.digit_skip = 1'b1;
        end
      end
      ST_EMIT: begin
        cmd.digit_out = 1'b1;
      end
      default: busy = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

FILE: sv/sbdt_dp.sv
// Datapath of the decimal text unit: magnitude shifter, BCD digit register
// with add-3 correction, counters and the result register. Depends on sbdt_pkg.
`default_nettype none

module sbdt_dp #(
  parameter int VALUE_BITS = sbdt_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = sbdt_pkg::MAX_DIGITS_DEF
) (
  input  wire                  clk,
  input  wire                  rst,
  input  sbdt_pkg::sbdt_in_t   value,
  input  sbdt_pkg::sbdt_cmd_t  cmd,
  output sbdt_pkg::sbdt_stat_t stat,
  output sbdt_pkg::sbdt_out_t  result,
  output logic                 strobe
);
  import sbdt_pkg::*;

  localparam int BCD_BITS = 4 * MAX_DIGITS;
  localparam int BW       = $clog2(VALUE_BITS);
  localparam int DW       = $clog2(MAX_DIGITS);
  localparam logic [BW-1:0] BIT_TOP = BW'(VALUE_BITS - 1);
  localparam logic [DW-1:0] DIG_TOP = DW'(MAX_DIGITS - 1);

  logic [VALUE_BITS-1:0] mag;
  logic [BCD_BITS-1:0]   bcd;
  logic [BW-1:0]         bit_cnt;
  logic [DW-1:0]         dig_cnt;
  logic                  negative;

  logic [2*HALF_BITS-1:0] full;
  logic [VALUE_BITS-1:0]  raw;
  logic [VALUE_BITS-1:0]  mag_load;
  logic [BCD_BITS-1:0]    bcd_adj;
  logic [3:0]             top_digit;

  assign full      = {value.value_high, value.value_low};
  assign raw       = full[VALUE_BITS-1:0];
  assign mag_load  = raw[VALUE_BITS-1] ? (~raw + VALUE_BITS'(1)) : raw;
  assign top_digit = bcd[BCD_BITS-1 -: 4];

  // add 3 to every digit of 5 or more before the doubling shift
  always_comb begin
    for (int d = 0; d < MAX_DIGITS; d++) begin
      bcd_adj[4*d +: 4] = (bcd[4*d +: 4] >= 4'd5) ? bcd[4*d +: 4] + 4'd3
                                                  : bcd[4*d +: 4];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mag      <= mag_load;
      negative <= raw[VALUE_BITS-1];
      bcd      <= '0;
      bit_cnt  <= BIT_TOP;
      dig_cnt  <= DIG_TOP;
    end
    if (cmd.step) begin
      mag     <= mag << 1;
      bcd     <= {bcd_adj[BCD_BITS-2:0], mag[VALUE_BITS-1]};
      bit_cnt <= bit_cnt - BW'(1);
    end
    if (cmd.digit_out || cmd.digit_skip) begin
      bcd     <= bcd << 4;
      dig_cnt <= dig_cnt - DW'(1);
    end
    if (cmd.sign_out) begin
      result.char_code <= CHAR_MINUS;
      result.last_char <= 1'b0;
    end
    if (cmd.digit_out) begin
      result.char_code <= CHAR_ZERO + {{(CHAR_BITS-4){1'b0}}, top_digit};
      result.last_char <= (dig_cnt == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= cmd.sign_out || cmd.digit_out;
    end
  end

  assign stat.bit_last = (bit_cnt == '0);
  assign stat.dig_last = (dig_cnt == '0);
  assign stat.top_nz   = (top_digit != 4'd0);
  assign stat.negative = negative;

endmodule

`default_nettype wire

FILE: sv/signed_binary_to_decimal_text_unit.sv
// Top level of the signed binary to decimal text unit.
// Depends on sbdt_pkg, sbdt_ctrl and sbdt_dp.
//
// Usage:
//   Input channel: drive value (two 64-bit halves of a two's complement
//   number, low VALUE_BITS bits used) and raise start; the beat is taken at
//   the clock edge where start is high and busy is low.
//   Output channel: each character appears on result for one cycle with
//   strobe high, most significant first; a minus sign leads a negative
//   number and result.last_char marks the final character.
//   Sequence: a load, one shift-and-add-3 step in the BCD register per
//   value bit, the sign when negative, then a scan over each of the
//   MAX_DIGITS digit positions (leading zeros are passed over without a
//   beat). The conversion loop is bit-serial and the scan takes one digit
//   per cycle; a new item is taken only once busy has dropped.
//   Characters leave in the cycle after they are formed; busy drops as the
//   last one leaves, so a new start may overlap its delivery.
//   Reset clears the controller to idle and the strobe; no item is kept.
//   The receiver cannot stall: it must take every beat as it is shown.
`default_nettype none

module signed_binary_to_decimal_text_unit #(
  parameter int VALUE_BITS = sbdt_pkg::VALUE_BITS_DEF,
  parameter int MAX_DIGITS = sbdt_pkg::MAX_DIGITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 start,
  output logic                busy,
  input  sbdt_pkg::sbdt_in_t  value,
  output sbdt_pkg::sbdt_out_t result,
  output logic                strobe
);
  import sbdt_pkg::*;

  sbdt_cmd_t  cmd;
  sbdt_stat_t stat;

  sbdt_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  sbdt_dp #(
    .VALUE_BITS (VALUE_BITS),
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .value  (value),
    .cmd    (cmd),
    .stat   (stat),
    .result (result),
    .strobe (strobe)
  );

endmodule

`default_nettype wire

FILE: tb/sv/signed_binary_to_decimal_text_unit_test.sv
`timescale 1ns / 100ps
// Testbench for signed_binary_to_decimal_text_unit: signed 128-bit values in, decimal
// ASCII text out. Predicts the text by repeated division and checks every character.
// Depends on sbdt_pkg and the unit's top level.

module signed_binary_to_decimal_text_unit_test;
  import sbdt_pkg::*;

  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_ITEMS  = 140;
  localparam int MAX_REPORTS   = 10;
  localparam int SETTLE_CYCLES = 200;

  typedef logic [VALUE_BITS_DEF-1:0] wide_t;

  typedef struct {
    sbdt_in_t operand;
    bit       drain_first;
  } pending_item_t;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  logic      busy;
  sbdt_in_t  value = '0;
  sbdt_out_t result;
  logic      strobe;

  logic beat_taken = 1'b0;

  pending_item_t pending_items[$];
  sbdt_out_t     expected_chars[$];

  int total_items = 0;
  int items_sent = 0;
  int items_accepted = 0;
  int negatives_seen = 0;
  int chars_checked = 0;
  int longest_text = 0;
  int failures = 0;
  int cycle_count = 0;
  int idle_left = 0;

  signed_binary_to_decimal_text_unit dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .value  (value),
    .result (result),
    .strobe (strobe)
  );

  always #5 clk = ~clk;

  function automatic wide_t ten_to(int k);
    wide_t p;
    p = 1;
    for (int i = 0; i < k; i++) p = p * 10;
    return p;
  endfunction

  // Push the characters that one accepted value must produce.
  function automatic void render_decimal(sbdt_in_t operand);
    wide_t     magnitude;
    bit        negative;
    int        digits[$];
    sbdt_out_t ch;
    magnitude = {operand.value_high, operand.value_low};
    negative = magnitude[VALUE_BITS_DEF-1];
    // the most negative value wraps to itself, read as unsigned 2^127
    if (negative) magnitude = ~magnitude + 1'b1;
    do begin
      digits.push_front(int'(magnitude % 10));
      magnitude = magnitude / 10;
    end while (magnitude != 0);
    if (negative) begin
      ch.char_code = CHAR_MINUS;
      ch.last_char = 1'b0;
      expected_chars.push_back(ch);
      negatives_seen++;
    end
    foreach (digits[i]) begin
      ch.char_code = CHAR_ZERO + CHAR_BITS'(digits[i]);
      ch.last_char = (i == digits.size() - 1);
      expected_chars.push_back(ch);
    end
    if (digits.size() + int'(negative) > longest_text)
      longest_text = digits.size() + int'(negative);
  endfunction

  function automatic void log_failure(string msg);
    failures++;
    if (failures <= MAX_REPORTS) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endfunction

  function automatic void queue_value(wide_t v, bit drain_first);
    pending_item_t item;
    item.operand = sbdt_in_t'(v);
    item.drain_first = drain_first;
    pending_items.push_back(item);
    total_items++;
  endfunction

  function automatic wide_t random_value();
    wide_t v;
    v = {$urandom, $urandom, $urandom, $urandom};
    case ($urandom_range(4))
      0: ;
      1: v = $urandom_range(0, 999);
      2: v = v >> $urandom_range(127);
      3: v = ten_to($urandom_range(0, 38)) + wide_t'($urandom_range(0, 6)) - 3;
      default: v = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}} + wide_t'($urandom_range(0, 8)) - 4;
    endcase
    if ($urandom_range(1)) v = -v;
    return v;
  endfunction

  function automatic int sender_idle_pct();
    if (items_sent < total_items / 3) return 25;
    if (items_sent < 2 * total_items / 3) return 80;
    return 0;
  endfunction

  // Sender: launch beats at the falling edge, hold start until a beat is taken.
  always @(negedge clk) begin : drive_values
    sbdt_in_t      next_value;
    logic          next_start;
    pending_item_t item;
    next_value = value;
    next_start = start;
    if (rst) begin
      next_start = 1'b0;
    end else if (!(start && !beat_taken)) begin
      next_start = 1'b0;
      if (beat_taken && $urandom_range(99) < sender_idle_pct())
        idle_left = $urandom_range(1, 200);
      if (idle_left > 0) begin
        idle_left--;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain_first && (expected_chars.size() != 0 || busy))) begin
        item = pending_items.pop_front();
        next_value = item.operand;
        next_start = 1'b1;
        items_sent++;
      end
    end
    start <= next_start;
    value <= next_value;
  end

  // Receiver: check characters first, then predict for a beat taken on this edge.
  always @(posedge clk) begin : check_chars
    sbdt_out_t want;
    beat_taken <= start && !busy && !rst;
    if (!rst && strobe) begin
      if (expected_chars.size() == 0) begin
        log_failure($sformatf("unexpected character code %0d last %0b",
                              result.char_code, result.last_char));
      end else begin
        want = expected_chars.pop_front();
        if (result.char_code !== want.char_code)
          log_failure($sformatf("char_code expected %0d got %0d",
                                want.char_code, result.char_code));
        if (result.last_char !== want.last_char)
          log_failure($sformatf("last_char expected %0b got %0b",
                                want.last_char, result.last_char));
        chars_checked++;
      end
    end
    if (!rst && start && !busy) begin
      render_decimal(value);
      items_accepted++;
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d characters outstanding",
               cycle_count, expected_chars.size());
      $display("FAIL");
      $finish;
    end
  end

  initial begin : run_test
    wide_t most_negative;
    most_negative = {1'b1, {(VALUE_BITS_DEF-1){1'b0}}};

    // zero, small values, sign boundaries and the widest texts
    queue_value(0, 1'b0);
    queue_value(1, 1'b0);
    queue_value(-1, 1'b0);
    queue_value(5, 1'b0);
    queue_value(-9, 1'b0);
    queue_value(9, 1'b0);
    queue_value(10, 1'b0);
    queue_value(-10, 1'b0);
    queue_value(most_negative - 1, 1'b0);
    queue_value(most_negative, 1'b0);
    queue_value(most_negative + 1, 1'b0);
    queue_value(ten_to(38) - 1, 1'b0);
    queue_value(ten_to(38), 1'b0);
    queue_value(-ten_to(38), 1'b0);
    queue_value(ten_to(19) - 1, 1'b0);
    queue_value(ten_to(20), 1'b0);
    queue_value({64'h0, {64{1'b1}}}, 1'b0);
    queue_value({64'h1, 64'h0}, 1'b0);
    queue_value({{64{1'b1}}, 64'h0}, 1'b0);
    queue_value({64'h0, 64'h8000_0000_0000_0000}, 1'b0);
    queue_value({64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa}, 1'b0);
    queue_value({64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555}, 1'b0);

    // drain before the random part and once more in the middle of it
    for (int i = 0; i < RANDOM_ITEMS; i++)
      queue_value(random_value(), i == 0 || i == RANDOM_ITEMS / 2);

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_items.size() != 0 || start) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (expected_chars.size() != 0)
      log_failure($sformatf("%0d characters never arrived", expected_chars.size()));

    $display("Converted %0d values (%0d negative, incl. zero, +/-2^127 and 39-digit texts).",
             items_accepted, negatives_seen);
    $display("Checked %0d characters, longest text %0d; %0d failures in %0d cycles.",
             chars_checked, longest_text, failures, cycle_count);
    if (failures == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
